@@ src/idq3ph_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq3ph_pkg
// Shared constants, types and the sine table generator for the inverse
// dq to three-phase transform.
// ----------------------------------------------------------------------------
package idq3ph_pkg;

  // Parameter defaults
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ANGLE_BITS_DEF  = 16;
  localparam int SINE_DEPTH_DEF  = 1024;

  // Quarter-wave sine magnitude, Q1.15 without sign
  localparam int SINE_MAG_BITS = 15;
  // Signed table value after quadrant sign
  localparam int SINE_VAL_BITS = SINE_MAG_BITS + 1;

  // sqrt(2/3) in Q0.16
  localparam int SCALE_BITS = 17;
  localparam logic [SCALE_BITS-1:0] SQRT_TWO_THIRDS_Q16 = 17'd53510;
  // Right shift of the scaled sum: Q15 table times Q16 constant
  localparam int ROUND_SHIFT = 31;

  // Table generation constants
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint Q29_HALF    = 64'sd536870912;
  localparam longint MAG_MAX     = 64'sd32767;

  typedef logic [SINE_MAG_BITS-1:0] sine_mag_t;

  // term * x^2 in Q30, each product truncated toward zero
  function automatic longint sq_step(input longint term, input longint x);
    longint t;
    t = (term * x) / Q30_ONE;
    return (t * x) / Q30_ONE;
  endfunction

  // sin(x) for x in Q30 radians, Taylor series through x^25, truncating
  // divisions, then rescaled to Q1.15 with round half up and clamp.
  // Divisors are (2n)(2n+1) for n = 1..12.
  function automatic sine_mag_t sine_entry(input longint x);
    longint term;
    longint sum;
    longint scaled;
    term = x;
    sum  = x;
    term = -sq_step(term, x) / 64'sd6;    sum = sum + term;
    term = -sq_step(term, x) / 64'sd20;   sum = sum + term;
    term = -sq_step(term, x) / 64'sd42;   sum = sum + term;
    term = -sq_step(term, x) / 64'sd72;   sum = sum + term;
    term = -sq_step(term, x) / 64'sd110;  sum = sum + term;
    term = -sq_step(term, x) / 64'sd156;  sum = sum + term;
    term = -sq_step(term, x) / 64'sd210;  sum = sum + term;
    term = -sq_step(term, x) / 64'sd272;  sum = sum + term;
    term = -sq_step(term, x) / 64'sd342;  sum = sum + term;
    term = -sq_step(term, x) / 64'sd420;  sum = sum + term;
    term = -sq_step(term, x) / 64'sd506;  sum = sum + term;
    term = -sq_step(term, x) / 64'sd600;  sum = sum + term;
    if (sum < 0) begin
      sum = 0;
    end
    scaled = (sum * MAG_MAX + Q29_HALF) / Q30_ONE;
    if (scaled > MAG_MAX) begin
      scaled = MAG_MAX;
    end
    return scaled[SINE_MAG_BITS-1:0];
  endfunction

endpackage

@@ src/idq3ph_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq3ph_in_if
// Input channel: dq voltage command and electrical angle, valid/ready.
// ----------------------------------------------------------------------------
interface idq3ph_in_if #(
  parameter int SAMPLE_BITS = idq3ph_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS  = idq3ph_pkg::ANGLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] vd;
  logic signed [SAMPLE_BITS-1:0] vq;
  logic        [ANGLE_BITS-1:0]  angle;

  modport source (output valid, vd, vq, angle, input ready);
  modport sink   (input valid, vd, vq, angle, output ready);
endinterface

@@ src/idq3ph_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq3ph_out_if
// Result channel: three phase voltages, valid/ready.
// ----------------------------------------------------------------------------
interface idq3ph_out_if #(
  parameter int SAMPLE_BITS = idq3ph_pkg::SAMPLE_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic signed [SAMPLE_BITS:0] phase_u;
  logic signed [SAMPLE_BITS:0] phase_v;
  logic signed [SAMPLE_BITS:0] phase_w;

  modport source (output valid, phase_u, phase_v, phase_w, input ready);
  modport sink   (input valid, phase_u, phase_v, phase_w, output ready);
endinterface

@@ src/inverse_dq_to_three_phase_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// inverse_dq_to_three_phase_core
// Power-invariant inverse Park/Clarke transform, seven-stage pipeline.
// ----------------------------------------------------------------------------
// Takes one (vd, vq, angle) beat per clock while not stalled and returns one
// (phase_u, phase_v, phase_w) beat per input, in order. The result beat moves
// through each stage register and is presented from the output register.
// Each phase is sqrt(2/3)*(cos(th)*vd - sin(th)*vq) with th = angle, angle -
// 1/3 turn and angle + 1/3 turn. Unless the output stalls, throughput is one
// beat per cycle, bounded by the sine lookup: six table reads per beat served
// by three copies of the quarter-wave ROM, each with two read ports. Every
// stage has its own valid bit and loads whenever the stage after it is empty
// or moving, so bubbles collapse and a stall on the output only holds the
// beats that are actually queued behind it; in_ch.ready drops only when all
// seven stages are full and the output beat is not taken. The sine ROM is
// built at elaboration and needs no fill after reset.
// ----------------------------------------------------------------------------
module inverse_dq_to_three_phase_core #(
  parameter int SAMPLE_BITS      = idq3ph_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS       = idq3ph_pkg::ANGLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = idq3ph_pkg::SINE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  idq3ph_in_if.sink      in_ch,
  idq3ph_out_if.source   out_ch
);
  import idq3ph_pkg::*;

  localparam int NSTG    = 7;
  localparam int NPH     = 3;   // u, v, w
  localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int OFS_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int LOW_W   = ANGLE_BITS - 2;
  localparam int STEP_W  = $clog2(4 * SINE_TABLE_DEPTH + 1);
  localparam int MUL_W   = LOW_W + STEP_W;
  localparam int PROD_W  = SAMPLE_BITS + SINE_VAL_BITS;
  localparam int SUM_W   = PROD_W + 1;
  localparam int SCL_W   = SUM_W + SCALE_BITS + 1;

  localparam logic [ANGLE_BITS-1:0] THIRD_TURN =
    ANGLE_BITS'(((64'd1 << ANGLE_BITS) + 64'd1) / 64'd3);
  localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = ANGLE_BITS'(64'd1 << (ANGLE_BITS - 2));
  localparam logic [STEP_W-1:0] OFS_STEP = STEP_W'(4 * SINE_TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] DEPTH_A  = ADDR_W'(SINE_TABLE_DEPTH);
  localparam logic signed [SCALE_BITS:0] SCALE_S = {1'b0, SQRT_TWO_THIRDS_Q16};
  localparam logic signed [SCL_W-1:0] RND_BIAS = SCL_W'(64'sd1 <<< (ROUND_SHIFT - 1));

  // Three ROM copies, one per phase; each read at sin and cos address.
  sine_mag_t sine_rom [NPH][SINE_TABLE_DEPTH+1];

  for (genvar p = 0; p < NPH; p++) begin : g_rom
    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_ent
      localparam longint XQ30 = (longint'(g) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      assign sine_rom[p][g] = sine_entry(XQ30);
    end
  end

  // Stage handshake: a stage loads when it is empty or its beat moves on.
  logic [NSTG:1] vld_r;
  logic [NSTG:1] en;

  always_comb begin
    en[NSTG] = !vld_r[NSTG] || out_ch.ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ch.ready  = en[1];
  assign out_ch.valid = vld_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) begin
        vld_r[1] <= in_ch.valid;
      end
      for (int k = 2; k <= NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // Stage 1: phase angles
  logic signed [SAMPLE_BITS-1:0] vd1_r, vq1_r;
  logic [ANGLE_BITS-1:0]         ang1_r [NPH];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      vd1_r     <= in_ch.vd;
      vq1_r     <= in_ch.vq;
      ang1_r[0] <= in_ch.angle;
      ang1_r[1] <= in_ch.angle - THIRD_TURN;
      ang1_r[2] <= in_ch.angle + THIRD_TURN;
    end
  end

  // Stage 2: quadrant fold into table address (index 0 sin, 1 cos)
  logic [ADDR_W-1:0] addr_nxt [NPH][2];
  logic              neg_nxt  [NPH][2];
  logic [ADDR_W-1:0] addr2_r  [NPH][2];
  logic              neg2_r   [NPH][2];
  logic signed [SAMPLE_BITS-1:0] vd2_r, vq2_r;

  always_comb begin
    logic [ANGLE_BITS-1:0] th;
    logic [MUL_W-1:0]      scaled;
    logic [OFS_W-1:0]      ofs;
    for (int p = 0; p < NPH; p++) begin
      for (int j = 0; j < 2; j++) begin
        th     = (j == 1) ? ang1_r[p] + QUARTER_TURN : ang1_r[p];
        scaled = MUL_W'(th[LOW_W-1:0]) * MUL_W'(OFS_STEP);
        ofs    = scaled[ANGLE_BITS +: OFS_W];
        addr_nxt[p][j] = th[ANGLE_BITS-1-1] ? DEPTH_A - ADDR_W'(ofs) : ADDR_W'(ofs);
        neg_nxt[p][j]  = th[ANGLE_BITS-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      addr2_r <= addr_nxt;
      neg2_r  <= neg_nxt;
      vd2_r   <= vd1_r;
      vq2_r   <= vq1_r;
    end
  end

  // Stage 3: registered ROM read
  sine_mag_t mag3_r [NPH][2];
  logic      neg3_r [NPH][2];
  logic signed [SAMPLE_BITS-1:0] vd3_r, vq3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int p = 0; p < NPH; p++) begin
        mag3_r[p][0] <= sine_rom[p][addr2_r[p][0]];
        mag3_r[p][1] <= sine_rom[p][addr2_r[p][1]];
      end
      neg3_r <= neg2_r;
      vd3_r  <= vd2_r;
      vq3_r  <= vq2_r;
    end
  end

  // Stage 4: apply quadrant sign, cos*vd and sin*vq
  logic signed [PROD_W-1:0] pc_nxt [NPH];
  logic signed [PROD_W-1:0] ps_nxt [NPH];
  logic signed [PROD_W-1:0] pc4_r  [NPH];
  logic signed [PROD_W-1:0] ps4_r  [NPH];

  always_comb begin
    logic signed [SINE_VAL_BITS-1:0] sv;
    logic signed [SINE_VAL_BITS-1:0] cv;
    for (int p = 0; p < NPH; p++) begin
      sv = neg3_r[p][0] ? -$signed({1'b0, mag3_r[p][0]}) : $signed({1'b0, mag3_r[p][0]});
      cv = neg3_r[p][1] ? -$signed({1'b0, mag3_r[p][1]}) : $signed({1'b0, mag3_r[p][1]});
      pc_nxt[p] = PROD_W'(vd3_r) * PROD_W'(cv);
      ps_nxt[p] = PROD_W'(vq3_r) * PROD_W'(sv);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      pc4_r <= pc_nxt;
      ps4_r <= ps_nxt;
    end
  end

  // Stage 5: difference
  logic signed [SUM_W-1:0] s5_r [NPH];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int p = 0; p < NPH; p++) begin
        s5_r[p] <= SUM_W'(pc4_r[p]) - SUM_W'(ps4_r[p]);
      end
    end
  end

  // Stage 6: scale by sqrt(2/3)
  logic signed [SCL_W-1:0] m6_r [NPH];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int p = 0; p < NPH; p++) begin
        m6_r[p] <= SCL_W'(s5_r[p]) * SCL_W'(SCALE_S);
      end
    end
  end

  // Stage 7: round half up, output register
  logic signed [SCL_W-1:0]     rnd [NPH];
  logic signed [SAMPLE_BITS:0] ph7_r [NPH];

  always_comb begin
    for (int p = 0; p < NPH; p++) begin
      rnd[p] = m6_r[p] + RND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int p = 0; p < NPH; p++) begin
        ph7_r[p] <= rnd[p][ROUND_SHIFT +: SAMPLE_BITS + 1];
      end
    end
  end

  assign out_ch.phase_u = ph7_r[0];
  assign out_ch.phase_v = ph7_r[1];
  assign out_ch.phase_w = ph7_r[2];

endmodule

@@ src/idq3ph_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idq3ph_check
// Port-level checks for the inverse dq to three-phase core, bound to it.
// ----------------------------------------------------------------------------
module idq3ph_check #(
  parameter int SAMPLE_BITS = idq3ph_pkg::SAMPLE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SAMPLE_BITS:0]  out_u,
  input logic [SAMPLE_BITS:0]  out_v,
  input logic [SAMPLE_BITS:0]  out_w
);

  // Stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // Stalled result payload holds
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_u) && $stable(out_v) && $stable(out_w))
    else $error("result payload changed while stalled");

  // Input is only back-pressured when the output side is stalled
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output free");

  // Reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

  // With no input valid and no result beat, a result beat may appear only if in_ready was high
  a_accept_only_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid && !out_valid |=> !out_valid || $past(in_ready))
    else $error("result beat without pipeline activity");

endmodule

bind inverse_dq_to_three_phase_core idq3ph_check #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_idq3ph_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_u     (out_ch.phase_u),
  .out_v     (out_ch.phase_v),
  .out_w     (out_ch.phase_w)
);
